// File: rtl/pmo_pkg.sv
// Types, widths and codes for the polyline miter offset block.
// Used by pmo_alu and polyline_miter_offset; depends on nothing.
package pmo_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int HW_WIDTH = 23;
  localparam logic [HW_WIDTH-1:0] HW_RESET = 23'd83886;
  localparam int UW = 80;   // shared unit operand width
  localparam int NW = 25;   // segment normal, signed
  localparam int MAGW = 48; // squared normal length
  localparam int DETW = 50; // cross product, signed
  localparam int OFFW = 64; // offset vector, signed
  localparam int SUMW = 66;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic          start;
    alu_op_t       op;
    logic [UW-1:0] a;
    logic [UW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [UW-1:0] q;
    logic [UW-1:0] r;
  } alu_res_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          is_final;
  } pmo_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] left_x;
    logic signed [COORD_WIDTH-1:0] left_y;
    logic signed [COORD_WIDTH-1:0] right_x;
    logic signed [COORD_WIDTH-1:0] right_y;
    logic                          end_of_route;
  } pmo_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NSHIFT,
    S_NSQX,
    S_NSQY,
    S_NSQRT,
    S_NMULX,
    S_NDIVX,
    S_NMULY,
    S_NDIVY,
    S_NRET,
    S_DET1,
    S_DET2,
    S_A1,
    S_A2,
    S_B1,
    S_B2,
    S_NX1,
    S_NX2,
    S_QX,
    S_NY1,
    S_NY2,
    S_QY,
    S_EMITA,
    S_EMITB,
    S_DONE
  } state_t;

endpackage

// File: rtl/polyline_miter_offset.sv
// Polyline offset with miter joins, top level: sequencer, state and output register.
// Depends on pmo_pkg and pmo_alu.
//
// Vertices come in on in_data (x, y in Q9.22, is_final on the route's last one)
// under in_valid / in_stall. Each request yields the result for the previous
// vertex: center, center plus offset (left) and center minus offset (right).
// The final vertex yields two results, or one for a single-point route.
// Results leave on out_data under out_valid / out_stall from one output
// register; the sequencer holds while that register is full and stalled.
// in_stall is high whenever the sequencer is out of S_IDLE, through S_DONE,
// which follows the request's last result entering the output register. Work
// is done by one shared unit, one bit per cycle. Each normal may first need
// prescale shifts; an end vertex costs one normal, an inner vertex two normals
// and the miter (ten multiplies, two divides). A first vertex that is not
// final is taken with no result.
// half_width is written through cfg_write / cfg_data; the user must do so only
// while idle, as the block itself does not enforce it.
// Reset (rst, synchronous) restores half_width to 0.02 and forgets the route.
module polyline_miter_offset (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pmo_pkg::pmo_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pmo_pkg::pmo_out_t               out_data,
  input  logic                            cfg_write,
  input  logic [pmo_pkg::HW_WIDTH-1:0]    cfg_data
);
  import pmo_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int AW = UW + 2;
  localparam logic [OFFW-1:0] MLIM = OFFW'(1) << 62;
  localparam logic [63:0] NLIM = 64'd1 << 30;

  state_t state, state_next;

  logic [HW_WIDTH-1:0] half_width;
  logic signed [W-1:0] before_x, before_y, pending_x, pending_y, cur_x, cur_y;
  logic                cur_fin;
  logic [1:0]          seen_count;
  logic                nsel, ubusy, sx_neg, sy_pos;
  logic [W:0]          ax, ay;
  logic [31:0]         len;
  logic signed [AW-1:0] acc, acc_next, sp;
  logic signed [NW-1:0] n1x, n1y, n2x, n2y, nval;
  logic [MAGW-1:0]     av, bv;
  logic signed [DETW-1:0] det;
  logic signed [OFFW-1:0] mx, my, mval;
  logic [UW-1:0]       rq, accmag, detmag, qq;

  alu_req_t req;
  alu_res_t res;
  logic     op_state, udone, clr, sub, neg, slot_free, emit, big;
  logic signed [W:0] dx, dy;
  pmo_out_t emit_data;

  pmo_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  function automatic logic [NW-1:0] nmag(input logic signed [NW-1:0] v);
    nmag = v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  function automatic logic [W:0] dmag(input logic signed [W:0] v);
    dmag = v[W] ? (W+1)'(-v) : (W+1)'(v);
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] p,
                                                  input logic signed [OFFW-1:0] m,
                                                  input logic sb);
    logic signed [SUMW-1:0] sum, hi, lo;
    hi = SUMW'((SUMW'(1) << (W - 1)) - 1);
    lo = -hi - SUMW'(1);
    sum = sb ? SUMW'(p) - SUMW'(m) : SUMW'(p) + SUMW'(m);
    if (sum > hi) sat_add = hi[W-1:0];
    else if (sum < lo) sat_add = lo[W-1:0];
    else sat_add = sum[W-1:0];
  endfunction

  // segment difference for the normal about to be computed
  always_comb begin
    if (state == S_IDLE) begin
      if (seen_count == 2'd1) begin
        dx = (W+1)'(in_data.point_x) - (W+1)'(pending_x);
        dy = (W+1)'(in_data.point_y) - (W+1)'(pending_y);
      end else begin
        dx = (W+1)'(pending_x) - (W+1)'(before_x);
        dy = (W+1)'(pending_y) - (W+1)'(before_y);
      end
    end else begin
      dx = (W+1)'(cur_x) - (W+1)'(pending_x);
      dy = (W+1)'(cur_y) - (W+1)'(pending_y);
    end
  end

  assign big = (64'(ax) >= NLIM) || (64'(ay) >= NLIM);

  // unit request per state
  always_comb begin
    op_state = 1'b1;
    req.op = OP_MUL;
    req.a = '0;
    req.b = '0;
    clr = 1'b0;
    sub = 1'b0;
    neg = 1'b0;
    case (state)
      S_NSQX: begin req.a = UW'(ax); req.b = UW'(ax); clr = 1'b1; end
      S_NSQY: begin req.a = UW'(ay); req.b = UW'(ay); end
      S_NSQRT: begin req.op = OP_SQRT; req.a = acc[UW-1:0]; end
      S_NMULX: begin req.a = UW'(ay); req.b = UW'(half_width); clr = 1'b1; end
      S_NMULY: begin req.a = UW'(ax); req.b = UW'(half_width); clr = 1'b1; end
      S_NDIVX, S_NDIVY: begin req.op = OP_DIV; req.a = acc[UW-1:0]; req.b = UW'(len); end
      S_DET1: begin
        req.a = UW'(nmag(n1x)); req.b = UW'(nmag(n2y));
        neg = n1x[NW-1] ^ n2y[NW-1]; clr = 1'b1;
      end
      S_DET2: begin
        req.a = UW'(nmag(n1y)); req.b = UW'(nmag(n2x));
        neg = n1y[NW-1] ^ n2x[NW-1]; sub = 1'b1;
      end
      S_A1: begin req.a = UW'(nmag(n1x)); req.b = UW'(nmag(n1x)); clr = 1'b1; end
      S_A2: begin req.a = UW'(nmag(n1y)); req.b = UW'(nmag(n1y)); end
      S_B1: begin req.a = UW'(nmag(n2x)); req.b = UW'(nmag(n2x)); clr = 1'b1; end
      S_B2: begin req.a = UW'(nmag(n2y)); req.b = UW'(nmag(n2y)); end
      S_NX1: begin req.a = UW'(av); req.b = UW'(nmag(n2y)); neg = n2y[NW-1]; clr = 1'b1; end
      S_NX2: begin req.a = UW'(bv); req.b = UW'(nmag(n1y)); neg = n1y[NW-1]; sub = 1'b1; end
      S_NY1: begin req.a = UW'(bv); req.b = UW'(nmag(n1x)); neg = n1x[NW-1]; clr = 1'b1; end
      S_NY2: begin req.a = UW'(av); req.b = UW'(nmag(n2x)); neg = n2x[NW-1]; sub = 1'b1; end
      S_QX, S_QY: begin req.op = OP_DIV; req.a = accmag; req.b = detmag; end
      default: op_state = 1'b0;
    endcase
    req.start = op_state && !ubusy;
  end

  assign udone = ubusy && res.done;
  assign sp = (neg ^ sub) ? -$signed({2'b00, res.q}) : $signed({2'b00, res.q});
  assign acc_next = (clr ? AW'(0) : acc) + sp;
  assign accmag = acc[AW-1] ? UW'(-acc) : UW'(acc);
  assign detmag = det[DETW-1] ? UW'(-det) : UW'(det);

  // normal component rounding, ties away from zero
  always_comb begin
    rq = res.q + UW'(res.r >= UW'(len) - res.r);
    if (state == S_NDIVX) nval = sy_pos ? -$signed(rq[NW-1:0]) : $signed(rq[NW-1:0]);
    else nval = sx_neg ? -$signed(rq[NW-1:0]) : $signed(rq[NW-1:0]);
  end

  // miter quotient: round, clamp at 2^62
  always_comb begin
    if (res.q >= UW'(MLIM)) qq = UW'(MLIM);
    else qq = res.q + UW'(res.r >= detmag - res.r);
    if (qq > UW'(MLIM)) qq = UW'(MLIM);
    mval = (acc[AW-1] ^ det[DETW-1]) ? -$signed(qq[OFFW-1:0]) : $signed(qq[OFFW-1:0]);
  end

  assign slot_free = !out_valid || !out_stall;
  assign emit = slot_free && (state == S_EMITA || state == S_EMITB);

  always_comb begin
    if (state == S_EMITA) begin
      emit_data.center_x = pending_x;
      emit_data.center_y = pending_y;
      emit_data.left_x = sat_add(pending_x, mx, 1'b0);
      emit_data.left_y = sat_add(pending_y, my, 1'b0);
      emit_data.right_x = sat_add(pending_x, mx, 1'b1);
      emit_data.right_y = sat_add(pending_y, my, 1'b1);
      emit_data.end_of_route = 1'b0;
    end else begin
      emit_data.center_x = cur_x;
      emit_data.center_y = cur_y;
      emit_data.left_x = sat_add(cur_x, OFFW'(n2x), 1'b0);
      emit_data.left_y = sat_add(cur_y, OFFW'(n2y), 1'b0);
      emit_data.right_x = sat_add(cur_x, OFFW'(n2x), 1'b1);
      emit_data.right_y = sat_add(cur_y, OFFW'(n2y), 1'b1);
      emit_data.end_of_route = 1'b1;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (seen_count == 2'd0) state_next = in_data.is_final ? S_EMITB : S_IDLE;
          else state_next = S_NSHIFT;
        end
      end
      S_NSHIFT: if (!big) state_next = S_NSQX;
      S_NSQX: if (udone) state_next = S_NSQY;
      S_NSQY: if (udone) state_next = S_NSQRT;
      S_NSQRT: if (udone) state_next = (res.q == '0) ? S_NRET : S_NMULX;
      S_NMULX: if (udone) state_next = S_NDIVX;
      S_NDIVX: if (udone) state_next = S_NMULY;
      S_NMULY: if (udone) state_next = S_NDIVY;
      S_NDIVY: if (udone) state_next = S_NRET;
      S_NRET: begin
        if (!nsel) state_next = S_NSHIFT;
        else if (seen_count == 2'd1) state_next = S_EMITA;
        else state_next = S_DET1;
      end
      S_DET1: if (udone) state_next = S_DET2;
      S_DET2: if (udone) state_next = (acc_next == '0) ? S_EMITA : S_A1;
      S_A1: if (udone) state_next = S_A2;
      S_A2: if (udone) state_next = S_B1;
      S_B1: if (udone) state_next = S_B2;
      S_B2: if (udone) state_next = S_NX1;
      S_NX1: if (udone) state_next = S_NX2;
      S_NX2: if (udone) state_next = S_QX;
      S_QX: if (udone) state_next = S_NY1;
      S_NY1: if (udone) state_next = S_NY2;
      S_NY2: if (udone) state_next = S_QY;
      S_QY: if (udone) state_next = S_EMITA;
      S_EMITA: if (slot_free) state_next = cur_fin ? S_EMITB : S_DONE;
      S_EMITB: if (slot_free) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      half_width <= HW_RESET;
      seen_count <= 2'd0;
      before_x   <= '0;
      before_y   <= '0;
      pending_x  <= '0;
      pending_y  <= '0;
      ubusy      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) half_width <= cfg_data;
      if (req.start) ubusy <= 1'b1;
      else if (res.done) ubusy <= 1'b0;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == S_IDLE && in_valid && seen_count == 2'd0 && !in_data.is_final) begin
        pending_x  <= in_data.point_x;
        pending_y  <= in_data.point_y;
        seen_count <= 2'd1;
      end
      if (state == S_DONE) begin
        if (cur_fin) begin
          seen_count <= 2'd0;
        end else begin
          before_x   <= pending_x;
          before_y   <= pending_y;
          pending_x  <= cur_x;
          pending_y  <= cur_y;
          seen_count <= 2'd2;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (emit) out_data <= emit_data;
    if (state == S_IDLE && in_valid) begin
      cur_x   <= in_data.point_x;
      cur_y   <= in_data.point_y;
      cur_fin <= in_data.is_final;
      nsel    <= (seen_count == 2'd1);
      n2x     <= '0;
      n2y     <= '0;
    end
    if ((state == S_IDLE && in_valid) || (state == S_NRET && !nsel)) begin
      ax     <= dmag(dx);
      ay     <= dmag(dy);
      sx_neg <= dx[W];
      sy_pos <= !dy[W] && (dy != '0);
    end
    if (state == S_NRET && !nsel) nsel <= 1'b1;
    if (state == S_NSHIFT && big) begin
      ax <= ax >> 1;
      ay <= ay >> 1;
    end
    if (udone && (state == S_NSQX || state == S_NSQY || state == S_NMULX ||
                  state == S_NMULY || state == S_DET1 || state == S_DET2 ||
                  state == S_A1 || state == S_A2 || state == S_B1 || state == S_B2 ||
                  state == S_NX1 || state == S_NX2 || state == S_NY1 ||
                  state == S_NY2)) begin
      acc <= acc_next;
    end
    if (udone && state == S_NSQRT) begin
      len <= res.q[31:0];
      if (res.q == '0) begin
        if (nsel) begin
          n2x <= '0;
          n2y <= '0;
        end else begin
          n1x <= '0;
          n1y <= '0;
        end
      end
    end
    if (udone && state == S_NDIVX) begin
      if (nsel) n2x <= nval;
      else n1x <= nval;
    end
    if (udone && state == S_NDIVY) begin
      if (nsel) n2y <= nval;
      else n1y <= nval;
    end
    if (state == S_NRET && nsel && seen_count == 2'd1) begin
      mx <= OFFW'(n2x);
      my <= OFFW'(n2y);
    end
    if (udone && state == S_DET2) begin
      det <= acc_next[DETW-1:0];
      // parallel or reversed segments: fall back to a segment normal
      if (n1x != '0 || n1y != '0) begin
        mx <= OFFW'(n1x);
        my <= OFFW'(n1y);
      end else begin
        mx <= OFFW'(n2x);
        my <= OFFW'(n2y);
      end
    end
    if (udone && state == S_A2) av <= acc_next[MAGW-1:0];
    if (udone && state == S_B2) bv <= acc_next[MAGW-1:0];
    if (udone && state == S_QX) mx <= mval;
    if (udone && state == S_QY) my <= mval;
  end

endmodule

// File: rtl/pmo_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide, bitwise square root.
// One step per cycle. Depends on pmo_pkg.
module pmo_alu (
  input  logic              clk,
  input  logic              rst,
  input  pmo_pkg::alu_req_t req,
  output pmo_pkg::alu_res_t res
);
  import pmo_pkg::*;

  localparam int CW = $clog2(UW + 1);

  logic [UW-1:0] x, y, x_next, y_next;
  logic [UW:0]   z, z_next, t, s;
  logic [CW-1:0] cnt;
  logic          busy, done;
  alu_op_t       op_r;

  always_comb begin
    t = {z[UW-1:0], x[UW-1]};
    s = z + {1'b0, y};
    x_next = x;
    y_next = y;
    z_next = z;
    case (op_r)
      OP_MUL: begin
        x_next = {x[UW-2:0], 1'b0};
        y_next = {1'b0, y[UW-1:1]};
        z_next = y[0] ? z + {1'b0, x} : z;
      end
      OP_DIV: begin
        if (t >= {1'b0, y}) begin
          z_next = t - {1'b0, y};
          x_next = {x[UW-2:0], 1'b1};
        end else begin
          z_next = t;
          x_next = {x[UW-2:0], 1'b0};
        end
      end
      OP_SQRT: begin
        y_next = {2'b00, y[UW-1:2]};
        if ({1'b0, x} >= s) begin
          x_next = x - s[UW-1:0];
          z_next = {1'b0, z[UW:1]} + {1'b0, y};
        end else begin
          z_next = {1'b0, z[UW:1]};
        end
      end
      default: begin
        z_next = z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op_r <= req.op;
        busy <= 1'b1;
        case (req.op)
          OP_DIV: cnt <= CW'(UW);
          default: cnt <= CW'(32);
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      z <= '0;
      x <= req.a;
      case (req.op)
        OP_SQRT: y <= UW'(1) << 62;
        default: y <= req.b;
      endcase
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign res.done = done;
  assign res.q    = (op_r == OP_DIV) ? x : z[UW-1:0];
  assign res.r    = z[UW-1:0];

endmodule
